// ===== rtl/salc_pkg.sv =====
package salc_pkg;

  // Default geometry
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;

  // Fixed field widths
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SB_W       = 3;
  localparam int BB_W       = 6;
  localparam int WU_W       = 4;
  localparam int SHAMT_W    = 7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS_USED  = 2'd2
  } cfg_idx_t;

  // Access opcodes
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } opcode_t;

  // Access outcomes
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  // Input transaction
  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] access_address;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]       outcome;
    logic             last_of_item;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_t;

endpackage

// ===== rtl/salc_way_ctrl.sv =====
module salc_way_ctrl #(
  parameter int MAX_WAYS = 8,
  parameter int AGE_W    = 3
) (
  input  logic [MAX_WAYS-1:0]                       way_use,
  input  logic [salc_pkg::TAG_W-1:0]                tag,
  input  logic [MAX_WAYS-1:0]                       line_valid,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]            line_age,
  input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  line_tag,
  output logic [MAX_WAYS-1:0]                       new_valid,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]            new_age,
  output logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  new_tag,
  output salc_pkg::outcome_t                        outcome
);
  import salc_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  logic             hit, empty;
  logic [WAY_W-1:0] hit_way, empty_way, vic_way, target;
  logic [AGE_W-1:0] best, limit;

  // Lookup: first hit, first free way, oldest way
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    best      = '0;
    vic_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (way_use[w] && line_valid[w] && (line_tag[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (way_use[w] && !line_valid[w]) begin
        empty     = 1'b1;
        empty_way = WAY_W'(w);
      end
    end
    // lowest way with the largest age wins a tie
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_use[w] && (line_age[w] > best)) begin
        best    = line_age[w];
        vic_way = WAY_W'(w);
      end
    end
  end

  assign target = hit ? hit_way : (empty ? empty_way : vic_way);
  assign limit  = hit ? line_age[target] : AGE_MAX;

  // Row update: age the younger ways, make the target most recent
  always_comb begin
    new_valid = line_valid;
    new_age   = line_age;
    new_tag   = line_tag;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_use[w] && (WAY_W'(w) != target) && line_valid[w] && (line_age[w] < limit)) begin
        new_age[w] = line_age[w] + AGE_W'(1);
      end
    end
    new_age[target]   = '0;
    new_valid[target] = 1'b1;
    new_tag[target]   = tag;
  end

  always_comb begin
    if (hit) begin
      outcome = OUT_HIT;
    end else if (empty) begin
      outcome = OUT_MISS;
    end else begin
      outcome = OUT_EVICT;
    end
  end

endmodule

// ===== rtl/set_assoc_lru_cache_sim_unit.sv =====
// Set-associative cache model with true-LRU replacement, one set row per memory entry.
// A result is registered when its access fires, once the accepted transaction's set row has been read.
// Throughput: loads and stores one per cycle while the output is not stalled; a modify makes two accesses,
// since each access hands its own result to the single output register.
// Reset (synchronous, active low) clears control and totals, resets configuration, and clears the
// per-set row-valid flags at once; there is no clearing pass.
module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  salc_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output salc_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);

  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ACC1 = 3'b010,
    ST_ACC2 = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [SB_W-1:0]    set_bits_r;
  logic [BB_W-1:0]    block_bits_r;
  logic [WU_W-1:0]    ways_used_r;
  logic [NUM_SETS-1:0] rowv_r;
  logic               rd_rowv_r;
  logic               use_fwd_r, use_fwd_nxt;
  logic               modify_r;
  logic [SET_W-1:0]   set_r;
  logic [TAG_W-1:0]   tag_r;
  row_t               row_mem_r [NUM_SETS];
  row_t               rd_row_r;
  row_t               fwd_row_r;
  logic [CNT_W-1:0]   hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CNT_W-1:0]   hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic               out_valid_r;
  out_t               out_data_r;

  logic [SB_W-1:0]    sb;
  logic [SHAMT_W-1:0] tag_shamt;
  logic [ADDR_W-1:0]  addr_shifted;
  logic [SET_W-1:0]   in_set;
  logic [TAG_W-1:0]   in_tag;
  logic [WCNT_W-1:0]  ways_eff;
  logic [MAX_WAYS-1:0] way_use;
  logic               accept, out_free, active, fire, last_acc, cfg_hit;
  row_t               cur_row, new_row;
  outcome_t           acc_outcome;

  // Address split: set index above the block offset, tag above that
  assign sb           = (set_bits_r > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : set_bits_r;
  assign tag_shamt    = {1'b0, block_bits_r} + {{(SHAMT_W-SB_W){1'b0}}, sb};
  assign addr_shifted = in_data.access_address >> block_bits_r;
  assign in_set       = addr_shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
  assign in_tag       = in_data.access_address >> tag_shamt;

  // Ways in use
  always_comb begin
    if (ways_used_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (ways_used_r > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_used_r);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_use[w] = WCNT_W'(w) < ways_eff;
    end
  end

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign active   = (state_r == ST_ACC1) || (state_r == ST_ACC2);
  assign last_acc = (state_r == ST_ACC2) || ((state_r == ST_ACC1) && !modify_r);
  assign fire     = active && out_free;
  assign in_stall = !((state_r == ST_IDLE) || (fire && last_acc));
  assign accept   = in_valid && !in_stall;

  // Row source: forwarded row after a write to the same set, else memory
  always_comb begin
    if (use_fwd_r) begin
      cur_row = fwd_row_r;
    end else begin
      cur_row = rd_row_r;
      if (!rd_rowv_r) begin
        cur_row.valid = '0;
        cur_row.age   = '0;
      end
    end
  end

  salc_way_ctrl #(
    .MAX_WAYS (MAX_WAYS),
    .AGE_W    (AGE_W)
  ) u_way_ctrl (
    .way_use    (way_use),
    .tag        (tag_r),
    .line_valid (cur_row.valid),
    .line_age   (cur_row.age),
    .line_tag   (cur_row.tag),
    .new_valid  (new_row.valid),
    .new_age    (new_row.age),
    .new_tag    (new_row.tag),
    .outcome    (acc_outcome)
  );

  // Saturating totals
  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (acc_outcome == OUT_HIT) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      if ((acc_outcome == OUT_EVICT) && (evict_cnt_r != '1)) begin
        evict_cnt_nxt = evict_cnt_r + CNT_W'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    use_fwd_nxt = use_fwd_r;
    if (accept) begin
      use_fwd_nxt = fire && (in_set == set_r);
      if (in_data.opcode inside {OP_LOAD, OP_STORE, OP_MODIFY}) begin
        state_nxt = ST_ACC1;
      end else begin
        state_nxt = ST_IDLE;
      end
    end else if (fire && !last_acc) begin
      state_nxt   = ST_ACC2;
      use_fwd_nxt = 1'b1;
    end else if (fire) begin
      state_nxt = ST_IDLE;
    end
  end

  assign cfg_hit = cfg_we && (cfg_index inside {CFG_SET_BITS, CFG_BLOCK_BITS, CFG_WAYS_USED});

  // Control state, configuration and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      use_fwd_r    <= 1'b0;
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_used_r  <= WU_W'(1);
      rowv_r       <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      use_fwd_r <= use_fwd_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SB_W-1:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BB_W-1:0];
          CFG_WAYS_USED:  ways_used_r  <= cfg_wdata[WU_W-1:0];
          default: ;
        endcase
      end
      // a write to any of the three configuration registers invalidates every line
      if (cfg_hit) begin
        rowv_r <= '0;
      end else if (fire) begin
        rowv_r[set_r] <= 1'b1;
      end
      if (fire) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      modify_r  <= (in_data.opcode == OP_MODIFY);
      set_r     <= in_set;
      tag_r     <= in_tag;
      rd_rowv_r <= rowv_r[in_set];
    end
    if (fire) begin
      fwd_row_r                 <= new_row;
      out_data_r.outcome        <= acc_outcome;
      out_data_r.last_of_item   <= last_acc;
      out_data_r.hit_total      <= hit_cnt_nxt;
      out_data_r.miss_total     <= miss_cnt_nxt;
      out_data_r.eviction_total <= evict_cnt_nxt;
    end
  end

  // Set row memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= row_mem_r[in_set];
    end
    if (fire) begin
      row_mem_r[set_r] <= new_row;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The second access of a modify always finds the line it just filled
  a_modify_second_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (state_r == ST_ACC2)) |-> (acc_outcome == OUT_HIT))
    else $error("second access of modify missed");

  // First half of a modify hands its row straight to the second half
  a_modify_forwards: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !last_acc) |=> ((state_r == ST_ACC2) && use_fwd_r))
    else $error("modify second access not forwarded");

  // A written-back set is marked as holding real row data
  a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg_hit) |=> rowv_r[$past(set_r)])
    else $error("row valid flag not set after write-back");

  // Totals never go backwards
  a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((hit_cnt_r >= $past(hit_cnt_r)) && (miss_cnt_r >= $past(miss_cnt_r)) &&
              (evict_cnt_r >= $past(evict_cnt_r))))
    else $error("running total decreased");

endmodule
